@@ design/lli_pkg.sv @@
// ----------------------------------------------------------------------------
// lli_pkg
// Shared widths, codes and types of the 2D line intersection core.
// ----------------------------------------------------------------------------
package lli_pkg;

	// coordinate width (signed, fixed point; the fraction cancels)
	localparam int CW   = 32;
	// coordinate difference
	localparam int DW   = CW + 1;
	// per-line cross determinant
	localparam int DETW = 2 * CW + 1;
	// x / y numerator
	localparam int NUMW = DETW + DW + 1;
	// denominator
	localparam int DENW = 2 * DW + 1;
	// divider operands: 2|n| + |d| and 2|d|
	localparam int MAGW = NUMW + 1;
	localparam int DMW  = DENW + 1;
	// quotient bits resolved by the divider, remainder width
	localparam int QW   = CW + 2;
	localparam int RW   = DMW + QW;
	// divider depth: range check stage plus one stage per quotient bit
	localparam int DIV_LAT = QW + 1;

	// result status codes
	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

endpackage

@@ design/lli_div.sv @@
// ----------------------------------------------------------------------------
// lli_div
// Pipelined restoring divider: one quotient bit per stage, with a leading
// range check that flags quotients too large for the bits resolved here.
// ----------------------------------------------------------------------------
module lli_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [lli_pkg::MAGW-1:0] n_in,
	input  logic [lli_pkg::DMW-1:0]  d_in,
	input  logic                     neg_in,
	output logic [lli_pkg::QW-1:0]   q,
	output logic                     hi,
	output logic                     neg
);

	logic [lli_pkg::RW-1:0]  rem_q [0:lli_pkg::QW-1];
	logic [lli_pkg::DMW-1:0] d_q   [0:lli_pkg::QW-1];
	logic [lli_pkg::QW-1:0]  q_q   [0:lli_pkg::QW];
	logic                    hi_q  [0:lli_pkg::QW];
	logic                    neg_q [0:lli_pkg::QW];

	// range check: quotient at or above 2^QW saturates anyway
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= lli_pkg::RW'(n_in);
			d_q[0]   <= d_in;
			q_q[0]   <= '0;
			hi_q[0]  <= lli_pkg::RW'(n_in) >= {d_in, {lli_pkg::QW{1'b0}}};
			neg_q[0] <= neg_in;
		end
	end

	// one trial subtract per stage, highest quotient bit first
	for (genvar j = 1; j <= lli_pkg::QW; j++) begin : g_st
		localparam int K = lli_pkg::QW - j;
		logic [lli_pkg::RW-1:0] dsh;
		logic [lli_pkg::RW:0]   diff;

		assign dsh  = {{lli_pkg::QW{1'b0}}, d_q[j-1]} << K;
		assign diff = {1'b0, rem_q[j-1]} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			if (en) begin
				hi_q[j]  <= hi_q[j-1];
				neg_q[j] <= neg_q[j-1];
				if (!diff[lli_pkg::RW]) begin
					q_q[j] <= q_q[j-1] | (lli_pkg::QW'(1) << K);
				end else begin
					q_q[j] <= q_q[j-1];
				end
			end
		end

		if (j < lli_pkg::QW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					d_q[j] <= d_q[j-1];
					if (!diff[lli_pkg::RW]) begin
						rem_q[j] <= diff[lli_pkg::RW-1:0];
					end else begin
						rem_q[j] <= rem_q[j-1];
					end
				end
			end
		end
	end

	assign q   = q_q[lli_pkg::QW];
	assign hi  = hi_q[lli_pkg::QW];
	assign neg = neg_q[lli_pkg::QW];

endmodule

@@ design/line_line_intersection_2d_core.sv @@
// ----------------------------------------------------------------------------
// line_line_intersection_2d_core
// Intersection of two infinite 2D lines by the determinant formula, with
// rounded (ties away from zero) division and saturation of the result.
// ----------------------------------------------------------------------------
// Pipeline from input word to output word: 7 arithmetic stages, 35 divider
// stages and the output register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, so the divider depth sets latency only.
// Reset clears the valid bits only; data registers are not reset.
module line_line_intersection_2d_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (32 bits each, from bit 0)
	input  logic [8*lli_pkg::CW-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// cross_x, cross_y (32 bits each, from bit 0)
	output logic [2*lli_pkg::CW-1:0]  m_tdata,
	// status
	output logic [1:0]                m_tuser
);

	localparam int CW   = lli_pkg::CW;
	localparam int DW   = lli_pkg::DW;
	localparam int DETW = lli_pkg::DETW;
	localparam int NUMW = lli_pkg::NUMW;
	localparam int DENW = lli_pkg::DENW;
	localparam int MAGW = lli_pkg::MAGW;
	localparam int DMW  = lli_pkg::DMW;
	localparam int QW   = lli_pkg::QW;
	localparam int DLAT = lli_pkg::DIV_LAT;

	logic en;

	// input fields
	logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	// stage 1: line products and differences
	logic                   v_s1;
	logic signed [2*CW-1:0] pa1_s1, pa2_s1, pb1_s1, pb2_s1;
	logic signed [DW-1:0]   dxa_s1, dxb_s1, dya_s1, dyb_s1;
	// stage 2: determinants and denominator products
	logic                   v_s2;
	logic signed [DETW-1:0] deta_s2, detb_s2;
	logic signed [2*DW-1:0] dd1_s2, dd2_s2;
	logic signed [DW-1:0]   dxa_s2, dxb_s2, dya_s2, dyb_s2;
	// stage 3: numerator partial products, denominator
	logic                   v_s3;
	logic signed [2*DW-1:0] xal_s3, xah_s3, xbl_s3, xbh_s3;
	logic signed [2*DW-1:0] yal_s3, yah_s3, ybl_s3, ybh_s3;
	logic signed [DENW-1:0] den_s3;
	// stage 4: full numerator terms
	logic                   v_s4;
	logic signed [NUMW-1:0] xa_s4, xb_s4, ya_s4, yb_s4;
	logic signed [DENW-1:0] den_s4;
	// stage 5: numerators
	logic                   v_s5;
	logic signed [NUMW-1:0] xn_s5, yn_s5;
	logic signed [DENW-1:0] den_s5;
	// stage 6: magnitudes and signs
	logic                   v_s6, par_s6, negx_s6, negy_s6;
	logic [NUMW-1:0]        ax_s6, ay_s6;
	logic [DENW-1:0]        ad_s6;
	// stage 7: divider operands
	logic                   v_s7, par_s7, negx_s7, negy_s7;
	logic [MAGW-1:0]        nx_s7, ny_s7;
	logic [DMW-1:0]         dm_s7;
	// beside the divider
	logic                   vd_q   [0:DLAT-1];
	logic                   pard_q [0:DLAT-1];
	// divider outputs
	logic [QW-1:0]          qx, qy;
	logic                   hix, hiy, negx, negy;
	logic [CW:0]            rx, ry;

	// whole pipeline advances unless the output word is held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign x1 = $signed(s_tdata[0*CW +: CW]);
	assign y1 = $signed(s_tdata[1*CW +: CW]);
	assign x2 = $signed(s_tdata[2*CW +: CW]);
	assign y2 = $signed(s_tdata[3*CW +: CW]);
	assign x3 = $signed(s_tdata[4*CW +: CW]);
	assign y3 = $signed(s_tdata[5*CW +: CW]);
	assign x4 = $signed(s_tdata[6*CW +: CW]);
	assign y4 = $signed(s_tdata[7*CW +: CW]);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < DLAT; i++) begin
				vd_q[i] <= 1'b0;
			end
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			vd_q[0] <= v_s7;
			for (int i = 1; i < DLAT; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
			m_tvalid <= vd_q[DLAT-1];
		end
	end

	// arithmetic stages 1 to 7
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			pa1_s1 <= x1 * y2;
			pa2_s1 <= y1 * x2;
			pb1_s1 <= x3 * y4;
			pb2_s1 <= y3 * x4;
			dxa_s1 <= DW'(x1) - DW'(x2);
			dxb_s1 <= DW'(x3) - DW'(x4);
			dya_s1 <= DW'(y1) - DW'(y2);
			dyb_s1 <= DW'(y3) - DW'(y4);
			// stage 2
			deta_s2 <= DETW'(pa1_s1) - DETW'(pa2_s1);
			detb_s2 <= DETW'(pb1_s1) - DETW'(pb2_s1);
			dd1_s2  <= dxa_s1 * dyb_s1;
			dd2_s2  <= dya_s1 * dxb_s1;
			dxa_s2  <= dxa_s1;
			dxb_s2  <= dxb_s1;
			dya_s2  <= dya_s1;
			dyb_s2  <= dyb_s1;
			// stage 3: determinants split into low unsigned and high signed halves
			xal_s3 <= $signed({1'b0, deta_s2[CW-1:0]}) * dxb_s2;
			xah_s3 <= $signed(deta_s2[DETW-1:CW]) * dxb_s2;
			xbl_s3 <= $signed({1'b0, detb_s2[CW-1:0]}) * dxa_s2;
			xbh_s3 <= $signed(detb_s2[DETW-1:CW]) * dxa_s2;
			yal_s3 <= $signed({1'b0, deta_s2[CW-1:0]}) * dyb_s2;
			yah_s3 <= $signed(deta_s2[DETW-1:CW]) * dyb_s2;
			ybl_s3 <= $signed({1'b0, detb_s2[CW-1:0]}) * dya_s2;
			ybh_s3 <= $signed(detb_s2[DETW-1:CW]) * dya_s2;
			den_s3 <= DENW'(dd1_s2) - DENW'(dd2_s2);
			// stage 4
			xa_s4  <= (NUMW'(xah_s3) <<< CW) + NUMW'(xal_s3);
			xb_s4  <= (NUMW'(xbh_s3) <<< CW) + NUMW'(xbl_s3);
			ya_s4  <= (NUMW'(yah_s3) <<< CW) + NUMW'(yal_s3);
			yb_s4  <= (NUMW'(ybh_s3) <<< CW) + NUMW'(ybl_s3);
			den_s4 <= den_s3;
			// stage 5
			xn_s5  <= xa_s4 - xb_s4;
			yn_s5  <= ya_s4 - yb_s4;
			den_s5 <= den_s4;
			// stage 6
			ax_s6   <= xn_s5[NUMW-1] ? NUMW'(-xn_s5) : NUMW'(xn_s5);
			ay_s6   <= yn_s5[NUMW-1] ? NUMW'(-yn_s5) : NUMW'(yn_s5);
			ad_s6   <= den_s5[DENW-1] ? DENW'(-den_s5) : DENW'(den_s5);
			negx_s6 <= (xn_s5[NUMW-1] != den_s5[DENW-1]) && (xn_s5 != '0);
			negy_s6 <= (yn_s5[NUMW-1] != den_s5[DENW-1]) && (yn_s5 != '0);
			par_s6  <= den_s5 == '0;
			// stage 7: 2|n| + |d| over 2|d| gives the rounded quotient
			nx_s7   <= {ax_s6, 1'b0} + MAGW'(ad_s6);
			ny_s7   <= {ay_s6, 1'b0} + MAGW'(ad_s6);
			dm_s7   <= {ad_s6, 1'b0};
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
			par_s7  <= par_s6;
		end
	end

	// parallel flag travels beside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			pard_q[0] <= par_s7;
			for (int i = 1; i < DLAT; i++) begin
				pard_q[i] <= pard_q[i-1];
			end
		end
	end

	lli_div u_div_x (
		.clk    (clk),
		.en     (en),
		.n_in   (nx_s7),
		.d_in   (dm_s7),
		.neg_in (negx_s7),
		.q      (qx),
		.hi     (hix),
		.neg    (negx)
	);

	lli_div u_div_y (
		.clk    (clk),
		.en     (en),
		.n_in   (ny_s7),
		.d_in   (dm_s7),
		.neg_in (negy_s7),
		.q      (qy),
		.hi     (hiy),
		.neg    (negy)
	);

	// signed result with saturation; top bit flags saturation
	function automatic logic [CW:0] sat_coord(input logic [QW-1:0] q, input logic hi,
			input logic neg);
		logic [QW-1:0] lim;
		logic [CW:0]   r;
		lim = QW'(1) << (CW - 1);
		if (neg) begin
			if (hi || q > lim) begin
				r = {1'b1, 1'b1, {(CW-1){1'b0}}};
			end else begin
				r = {1'b0, (~q[CW-1:0]) + CW'(1)};
			end
		end else begin
			if (hi || q > lim - QW'(1)) begin
				r = {1'b1, 1'b0, {(CW-1){1'b1}}};
			end else begin
				r = {1'b0, q[CW-1:0]};
			end
		end
		return r;
	endfunction

	assign rx = sat_coord(qx, hix, negx);
	assign ry = sat_coord(qy, hiy, negy);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (pard_q[DLAT-1]) begin
				m_tdata <= '0;
				m_tuser <= lli_pkg::ST_PARALLEL;
			end else begin
				m_tdata <= {ry[CW-1:0], rx[CW-1:0]};
				m_tuser <= (rx[CW] || ry[CW]) ? lli_pkg::ST_RANGE : lli_pkg::ST_FOUND;
			end
		end
	end

endmodule

@@ tb/sv/tb_line_line_intersection_2d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_line_intersection_2d_core
// Drives segment pairs into the intersection core over the input stream and
// checks each result word against a wide-integer determinant predictor:
// rounding, parallel lines, saturation and back-pressure at random phases.
// ----------------------------------------------------------------------------
module tb_line_line_intersection_2d_core;

	localparam int CW = lli_pkg::CW;

	typedef logic [7:0][CW-1:0] seg_pair_t; // ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [1:0]    st;
	} cross_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [8*CW-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [2*CW-1:0]    m_tdata;
	logic [1:0]         m_tuser;

	seg_pair_t pending_pairs[$];
	cross_t    expected_cross[$];
	logic      took = 1'b0;
	int        accepted = 0;
	int        fails = 0;
	int        stall_left = 0;
	bit        stall_done = 0;
	bit        stim_done = 0;

	line_line_intersection_2d_core DUT (.*);

	always #10 clk = ~clk;

	// rounded quotient n/d, ties away from zero, saturated to CW bits
	function automatic logic [CW-1:0] round_quot(logic signed [159:0] n,
			logic signed [159:0] d, output bit sat);
		logic [159:0] mn, md, q;
		bit neg;
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		neg = ((n < 0) != (d < 0)) && n != 0;
		q = (2 * mn + md) / (2 * md);
		sat = 0;
		if (neg) begin
			if (q > (160'd1 << (CW - 1))) begin
				sat = 1;
				return {1'b1, {(CW - 1){1'b0}}};
			end
			return -q[CW-1:0];
		end
		if (q > (160'd1 << (CW - 1)) - 1) begin
			sat = 1;
			return {1'b0, {(CW - 1){1'b1}}};
		end
		return q[CW-1:0];
	endfunction

	function automatic cross_t predict_cross(seg_pair_t p);
		logic signed [159:0] c[8];
		logic signed [159:0] deta, detb, dxa, dxb, dya, dyb, xn, yn, den;
		cross_t r;
		bit sx, sy;
		for (int i = 0; i < 8; i++) c[i] = $signed(p[i]);
		deta = c[0] * c[3] - c[1] * c[2];
		detb = c[4] * c[7] - c[5] * c[6];
		dxa = c[0] - c[2];
		dya = c[1] - c[3];
		dxb = c[4] - c[6];
		dyb = c[5] - c[7];
		xn = deta * dxb - dxa * detb;
		yn = deta * dyb - dya * detb;
		den = dxa * dyb - dya * dxb;
		if (den == 0) begin
			r.x = '0;
			r.y = '0;
			r.st = lli_pkg::ST_PARALLEL;
		end else begin
			r.x = round_quot(xn, den, sx);
			r.y = round_quot(yn, den, sy);
			r.st = (sx || sy) ? lli_pkg::ST_RANGE : lli_pkg::ST_FOUND;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		fails++;
	endtask

	function automatic logic [CW-1:0] small_coord();
		return $signed($urandom) >>> $urandom_range(6, 14);
	endfunction

	// random pair; shape: 0 full range, 1 small, 2 parallel, 3 near parallel
	function automatic seg_pair_t random_pair(int shape);
		seg_pair_t p;
		for (int i = 0; i < 8; i++) p[i] = shape == 0 ? $urandom : small_coord();
		if (shape >= 2) begin
			p[6] = p[4] + p[2] - p[0];
			p[7] = p[5] + p[3] - p[1];
			if (shape == 3) p[7] = p[7] + ($urandom_range(0, 1) ? 1 : -1);
		end
		return p;
	endfunction

	// driver: new word at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (took) void'(pending_pairs.pop_front());
		if (arst_n && (!s_tvalid || took)) begin
			int pct;
			pct = (accepted / 150) % 4 == 1 ? 60 : (accepted / 150) % 4 == 3 ? 25 : 0;
			if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_pairs[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, including one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			int pct;
			pct = (accepted / 150) % 4 == 2 ? 60 : (accepted / 150) % 4 == 3 ? 25 : 0;
			if (!stall_done && accepted >= 600) begin
				stall_done <= 1;
				stall_left <= 400;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 99) >= pct;
			end
		end
	end

	// input acceptance: predict the result word
	always @(posedge clk) begin
		took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			expected_cross.push_back(predict_cross(s_tdata));
			accepted <= accepted + 1;
		end
	end

	// output check against the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_cross.size() == 0) begin
				$display("%0t: result word with nothing expected", $realtime);
				fails++;
			end else begin
				cross_t e;
				e = expected_cross.pop_front();
				if (m_tdata[CW-1:0] !== e.x) report_mismatch("cross_x", m_tdata[CW-1:0], e.x);
				if (m_tdata[2*CW-1:CW] !== e.y)
					report_mismatch("cross_y", m_tdata[2*CW-1:CW], e.y);
				if (m_tuser !== e.st) report_mismatch("status", CW'(m_tuser), CW'(e.st));
			end
		end
	end

	initial begin
		seg_pair_t p;
		// directed: extremes, crossing, ties, parallel, degenerate, range
		p = '0;                                  pending_pairs.push_back(p);
		p = '1;                                  pending_pairs.push_back(p);
		for (int i = 0; i < 8; i++) p[i] = 32'h7fffffff; pending_pairs.push_back(p);
		for (int i = 0; i < 8; i++) p[i] = 32'h80000000; pending_pairs.push_back(p);
		p = {32'h00010000, 32'h0, 32'hffff0000, 32'h0,
		     32'h0, 32'h00010000, 32'h0, 32'hffff0000};  pending_pairs.push_back(p);
		p = {32'd3, 32'd3, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd3}; pending_pairs.push_back(p);
		p = {32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1}; pending_pairs.push_back(p);
		p = {-32'sd1, -32'sd1, 32'd0, 32'd0, -32'sd1, 32'd0, 32'd0, -32'sd1};
		pending_pairs.push_back(p);
		p = {32'd5, 32'd4, 32'd1, 32'd0, 32'd4, 32'd3, 32'd1, 32'd0}; pending_pairs.push_back(p);
		p = {32'd7, 32'd9, 32'd7, 32'd9, 32'd5, 32'd4, 32'd1, 32'd0}; pending_pairs.push_back(p);
		p = {32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
		     32'h80000001, 32'h80000000, 32'h7fffffff, 32'h7ffffffe};
		pending_pairs.push_back(p);
		p = {32'd1, 32'h7fffffff, 32'd0, 32'd0, 32'd0, 32'h7fffffff, 32'd1, 32'd0};
		pending_pairs.push_back(p);
		p = {32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
		     32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000};
		pending_pairs.push_back(p);
		for (int i = 0; i < 4; i++) pending_pairs.push_back(random_pair(2));
		for (int i = 0; i < 4; i++) pending_pairs.push_back(random_pair(3));
		// random: mostly well-conditioned pairs, with wild and parallel ones
		for (int i = 0; i < 1200; i++) begin
			int r;
			r = $urandom_range(0, 99);
			pending_pairs.push_back(random_pair(r < 25 ? 0 : r < 75 ? 1 : r < 87 ? 2 : 3));
		end
		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		wait (pending_pairs.size() == 0 && expected_cross.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(20 * 300000);
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
design/lli_pkg.sv
design/lli_div.sv
design/line_line_intersection_2d_core.sv
tb/sv/tb_line_line_intersection_2d_core.sv
